// ===== design/slpool_pkg.sv =====
package slpool_pkg;

   localparam int POOL_NODES_DEF = 128;
   localparam int NUM_LISTS_DEF  = 8;
   localparam int KEY_W          = 32;

   localparam logic [2:0] MODE_RESET  = 3'd0;
   localparam logic [2:0] MODE_CREATE = 3'd1;
   localparam logic [2:0] MODE_INSERT = 3'd2;
   localparam logic [2:0] MODE_DELETE = 3'd3;
   localparam logic [2:0] MODE_LENGTH = 3'd4;
   localparam logic [2:0] MODE_USED   = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_FREE   = 2'd1;
   localparam logic [1:0] ST_EMPTY     = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [2:0]              mode;
      logic [2:0]              list_id;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] list_length;
      logic [7:0] used_nodes;
   } rsp_type;

endpackage

// ===== design/slpool_ram.sv =====
module slpool_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/sorted_list_pool_with_free_list.sv =====
// A pool of POOL_NODES nodes holds NUM_LISTS ascending doubly linked lists of
// signed keys plus a free list; one command is processed at a time and answers
// with exactly one response beat. Reset and a pool rebuild take effect at once:
// the untouched tail of the pool is tracked by a fill pointer, so no clearing
// pass runs. Create returns the nodes of the old list one by one, and insert
// and delete walk the list from its head; a finished command waits while a
// response beat is still to be taken. The walk is set by the node memory: one
// registered read, then the compare, for each node on the path.
module sorted_list_pool_with_free_list #(
   parameter int POOL_NODES = slpool_pkg::POOL_NODES_DEF,
   parameter int NUM_LISTS  = slpool_pkg::NUM_LISTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  slpool_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output slpool_pkg::rsp_type rsp_data
);

   import slpool_pkg::*;

   localparam int AW  = $clog2(POOL_NODES);
   localparam int NW  = $clog2(POOL_NODES + 1);
   localparam int LW  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam int EW  = KEY_W + 2 * NW;
   localparam int LEW = 2 * NW;
   localparam int CW  = (NW > 8) ? NW : 8;
   localparam logic [NW-1:0] NULL_NODE = NW'(POOL_NODES);

   typedef enum logic [16:0] {
      S_IDLE       = 17'h00001,
      S_LIST       = 17'h00002,
      S_FREE_RD    = 17'h00004,
      S_FREE_WR    = 17'h00008,
      S_TAKE       = 17'h00010,
      S_TAKE_WAIT  = 17'h00020,
      S_CREATE_WR  = 17'h00040,
      S_WALK_RD    = 17'h00080,
      S_WALK_CHK   = 17'h00100,
      S_INS_WN     = 17'h00200,
      S_INS_WCUR   = 17'h00400,
      S_INS_WPRV   = 17'h00800,
      S_DEL_LINK   = 17'h01000,
      S_DEL_NXT_RD = 17'h02000,
      S_DEL_NXT_WR = 17'h04000,
      S_DEL_GIVE   = 17'h08000,
      S_RESP       = 17'h10000
   } state_type;

   function automatic logic [7:0] sat8(input logic [NW-1:0] v);
      return (CW'(v) > CW'(255)) ? 8'hFF : 8'(v);
   endfunction

   state_type               state_ff, state_in;
   logic [2:0]              mode_ff, mode_in;
   logic [LW-1:0]           lid_ff, lid_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [1:0]              status_ff, status_in;
   logic [NW-1:0]           first_ff, first_in;
   logic [NW-1:0]           cnt_ff, cnt_in;
   logic [NW-1:0]           cur_ff, cur_in;
   logic [NW-1:0]           prv_ff, prv_in;
   logic [NW-1:0]           new_ff, new_in;
   logic [EW-1:0]           cur_q_ff, cur_q_in;
   logic [EW-1:0]           prv_q_ff, prv_q_in;
   logic [NW-1:0]           free_head_ff, free_head_in;
   logic [NW-1:0]           fresh_ff, fresh_in;
   logic [NW-1:0]           alloc_ff, alloc_in;
   logic [NUM_LISTS-1:0]    list_vld_ff, list_vld_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    nram_wr_en, nram_rd_en;
   logic [AW-1:0]           nram_wr_addr, nram_rd_addr;
   logic [EW-1:0]           nram_wr_data, nram_rd_data;
   logic                    lram_wr_en, lram_rd_en;
   logic [LW-1:0]           lram_wr_addr, lram_rd_addr;
   logic [LEW-1:0]          lram_wr_data, lram_rd_data;

   logic [8:0]              lid_wrap;
   logic [LW-1:0]           req_lid;
   logic                    req_fire;
   logic                    take_done;
   logic signed [KEY_W-1:0] rd_key;
   logic [NW-1:0]           rd_next;
   logic [NW-1:0]           cur_q_next;
   logic [NW-1:0]           alloc_dec;

   slpool_ram #(.WIDTH(EW), .DEPTH(POOL_NODES)) u_node_ram (
      .clock   (clock),
      .wr_en   (nram_wr_en),
      .wr_addr (nram_wr_addr),
      .wr_data (nram_wr_data),
      .rd_en   (nram_rd_en),
      .rd_addr (nram_rd_addr),
      .rd_data (nram_rd_data)
   );

   slpool_ram #(.WIDTH(LEW), .DEPTH(NUM_LISTS)) u_list_ram (
      .clock   (clock),
      .wr_en   (lram_wr_en),
      .wr_addr (lram_wr_addr),
      .wr_data (lram_wr_data),
      .rd_en   (lram_rd_en),
      .rd_addr (lram_rd_addr),
      .rd_data (lram_rd_data)
   );

   // The list number is narrow, so the wrap is a few conditional subtracts.
   always_comb begin
      lid_wrap = 9'(req_data.list_id);
      for (int i = 0; i < 7; i++) begin
         if (lid_wrap >= 9'(NUM_LISTS)) begin
            lid_wrap = lid_wrap - 9'(NUM_LISTS);
         end
      end
   end

   assign req_lid    = lid_wrap[LW-1:0];
   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign rd_key     = nram_rd_data[EW-1 -: KEY_W];
   assign rd_next    = nram_rd_data[2*NW-1 -: NW];
   assign cur_q_next = cur_q_ff[2*NW-1 -: NW];
   assign alloc_dec  = (alloc_ff != '0) ? alloc_ff - NW'(1) : alloc_ff;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      lid_in       = lid_ff;
      key_in       = key_ff;
      status_in    = status_ff;
      first_in     = first_ff;
      cnt_in       = cnt_ff;
      cur_in       = cur_ff;
      prv_in       = prv_ff;
      new_in       = new_ff;
      cur_q_in     = cur_q_ff;
      prv_q_in     = prv_q_ff;
      free_head_in = free_head_ff;
      fresh_in     = fresh_ff;
      alloc_in     = alloc_ff;
      list_vld_in  = list_vld_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      nram_wr_en   = 1'b0;
      nram_wr_addr = cur_ff[AW-1:0];
      nram_wr_data = cur_q_ff;
      nram_rd_en   = 1'b0;
      nram_rd_addr = cur_ff[AW-1:0];
      lram_wr_en   = 1'b0;
      lram_wr_addr = lid_ff;
      lram_wr_data = {cnt_ff, first_ff};
      lram_rd_en   = req_fire;
      lram_rd_addr = req_lid;
      take_done    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in   = req_data.mode;
               lid_in    = req_lid;
               key_in    = req_data.key;
               status_in = ST_OK;
               if (req_data.mode == MODE_RESET) begin
                  list_vld_in  = '0;
                  free_head_in = '0;
                  fresh_in     = '0;
                  alloc_in     = '0;
                  cnt_in       = '0;
                  state_in     = S_RESP;
               end else begin
                  state_in = S_LIST;
               end
            end
         end

         S_LIST: begin
            first_in = list_vld_ff[lid_ff] ? lram_rd_data[NW-1:0] : NULL_NODE;
            cnt_in   = list_vld_ff[lid_ff] ? lram_rd_data[LEW-1 -: NW] : '0;
            cur_in   = first_in;
            prv_in   = NULL_NODE;
            unique case (mode_ff)
               MODE_CREATE: begin
                  state_in = (first_in != NULL_NODE) ? S_FREE_RD : S_TAKE;
               end
               MODE_INSERT: begin
                  state_in = S_TAKE;
               end
               MODE_DELETE: begin
                  if (first_in == NULL_NODE) begin
                     status_in = ST_EMPTY;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_WALK_RD;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end

         S_FREE_RD: begin
            nram_rd_en = 1'b1;
            state_in   = S_FREE_WR;
         end

         // Push the node onto the free list and follow its old link.
         S_FREE_WR: begin
            nram_wr_en   = 1'b1;
            nram_wr_data = {rd_key, free_head_ff, NULL_NODE};
            free_head_in = cur_ff;
            alloc_in     = alloc_dec;
            cur_in       = rd_next;
            if (rd_next == NULL_NODE) begin
               first_in = NULL_NODE;
               cnt_in   = '0;
               state_in = S_TAKE;
            end else begin
               state_in = S_FREE_RD;
            end
         end

         // Nodes at or past the fill pointer were never handed out since the
         // last rebuild, so their link is simply the next index.
         S_TAKE: begin
            new_in = free_head_ff;
            if (free_head_ff == NULL_NODE) begin
               status_in = ST_NO_FREE;
               if (mode_ff == MODE_CREATE) begin
                  lram_wr_en   = 1'b1;
                  lram_wr_data = {NW'(0), NULL_NODE};
                  list_vld_in[lid_ff] = 1'b1;
               end
               state_in = S_RESP;
            end else if (free_head_ff == fresh_ff) begin
               free_head_in = free_head_ff + NW'(1);
               fresh_in     = free_head_ff + NW'(1);
               alloc_in     = alloc_ff + NW'(1);
               take_done    = 1'b1;
            end else begin
               nram_rd_en   = 1'b1;
               nram_rd_addr = free_head_ff[AW-1:0];
               state_in     = S_TAKE_WAIT;
            end
         end

         S_TAKE_WAIT: begin
            free_head_in = rd_next;
            alloc_in     = alloc_ff + NW'(1);
            take_done    = 1'b1;
         end

         S_CREATE_WR: begin
            nram_wr_en   = 1'b1;
            nram_wr_addr = new_ff[AW-1:0];
            nram_wr_data = {key_ff, NULL_NODE, NULL_NODE};
            lram_wr_en   = 1'b1;
            lram_wr_data = {NW'(1), new_ff};
            list_vld_in[lid_ff] = 1'b1;
            cnt_in       = NW'(1);
            state_in     = S_RESP;
         end

         S_WALK_RD: begin
            nram_rd_en = 1'b1;
            state_in   = S_WALK_CHK;
         end

         S_WALK_CHK: begin
            if (mode_ff == MODE_INSERT) begin
               if (key_ff > rd_key) begin
                  prv_in   = cur_ff;
                  prv_q_in = nram_rd_data;
                  cur_in   = rd_next;
                  state_in = (rd_next == NULL_NODE) ? S_INS_WN : S_WALK_RD;
               end else begin
                  cur_q_in = nram_rd_data;
                  state_in = S_INS_WN;
               end
            end else begin
               if (rd_key == key_ff) begin
                  cur_q_in = nram_rd_data;
                  state_in = S_DEL_LINK;
               end else if (rd_next == NULL_NODE) begin
                  status_in = ST_NOT_FOUND;
                  state_in  = S_RESP;
               end else begin
                  prv_in   = cur_ff;
                  prv_q_in = nram_rd_data;
                  cur_in   = rd_next;
                  state_in = S_WALK_RD;
               end
            end
         end

         S_INS_WN: begin
            nram_wr_en   = 1'b1;
            nram_wr_addr = new_ff[AW-1:0];
            nram_wr_data = {key_ff, cur_ff, prv_ff};
            lram_wr_en   = 1'b1;
            lram_wr_data = {cnt_ff + NW'(1), (prv_ff != NULL_NODE) ? first_ff : new_ff};
            list_vld_in[lid_ff] = 1'b1;
            cnt_in       = cnt_ff + NW'(1);
            if (cur_ff != NULL_NODE) begin
               state_in = S_INS_WCUR;
            end else if (prv_ff != NULL_NODE) begin
               state_in = S_INS_WPRV;
            end else begin
               state_in = S_RESP;
            end
         end

         S_INS_WCUR: begin
            nram_wr_en   = 1'b1;
            nram_wr_data = {cur_q_ff[EW-1:NW], new_ff};
            state_in     = (prv_ff != NULL_NODE) ? S_INS_WPRV : S_RESP;
         end

         S_INS_WPRV: begin
            nram_wr_en   = 1'b1;
            nram_wr_addr = prv_ff[AW-1:0];
            nram_wr_data = {prv_q_ff[EW-1 -: KEY_W], new_ff, prv_q_ff[NW-1:0]};
            state_in     = S_RESP;
         end

         // Bypass the found node from its predecessor or from the list head.
         S_DEL_LINK: begin
            if (prv_ff != NULL_NODE) begin
               nram_wr_en   = 1'b1;
               nram_wr_addr = prv_ff[AW-1:0];
               nram_wr_data = {prv_q_ff[EW-1 -: KEY_W], cur_q_next, prv_q_ff[NW-1:0]};
            end else begin
               first_in = cur_q_next;
            end
            cnt_in       = (cnt_ff != '0) ? cnt_ff - NW'(1) : cnt_ff;
            lram_wr_en   = 1'b1;
            lram_wr_data = {cnt_in, first_in};
            list_vld_in[lid_ff] = 1'b1;
            state_in     = (cur_q_next != NULL_NODE) ? S_DEL_NXT_RD : S_DEL_GIVE;
         end

         S_DEL_NXT_RD: begin
            nram_rd_en   = 1'b1;
            nram_rd_addr = cur_q_next[AW-1:0];
            state_in     = S_DEL_NXT_WR;
         end

         S_DEL_NXT_WR: begin
            nram_wr_en   = 1'b1;
            nram_wr_addr = cur_q_next[AW-1:0];
            nram_wr_data = {rd_key, rd_next, prv_ff};
            state_in     = S_DEL_GIVE;
         end

         S_DEL_GIVE: begin
            nram_wr_en   = 1'b1;
            nram_wr_data = {cur_q_ff[EW-1 -: KEY_W], free_head_ff, NULL_NODE};
            free_head_in = cur_ff;
            alloc_in     = alloc_dec;
            state_in     = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = status_ff;
               rsp_data_in.list_length = sat8(cnt_ff);
               rsp_data_in.used_nodes  = sat8(alloc_ff);
               state_in                = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A node has been taken: create writes it, insert starts its walk or, into an empty list, writes it at once.
      if (take_done) begin
         if (mode_ff == MODE_CREATE) begin
            state_in = S_CREATE_WR;
         end else begin
            cur_in   = first_ff;
            prv_in   = NULL_NODE;
            state_in = (first_ff != NULL_NODE) ? S_WALK_RD : S_INS_WN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_head_ff <= '0;
         fresh_ff     <= '0;
         alloc_ff     <= '0;
         list_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
         alloc_ff     <= alloc_in;
         list_vld_ff  <= list_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      lid_ff      <= lid_in;
      key_ff      <= key_in;
      status_ff   <= status_in;
      first_ff    <= first_in;
      cnt_ff      <= cnt_in;
      cur_ff      <= cur_in;
      prv_ff      <= prv_in;
      new_ff      <= new_in;
      cur_q_ff    <= cur_q_in;
      prv_q_ff    <= prv_q_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/slpool_check.sv =====
module slpool_check #(
   parameter int POOL_NODES = slpool_pkg::POOL_NODES_DEF
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input slpool_pkg::req_type req_data,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input slpool_pkg::rsp_type rsp_data
);

   import slpool_pkg::*;

   localparam logic [7:0] USED_MAX = (POOL_NODES > 255) ? 8'd255 : 8'(POOL_NODES);

   // A request beat that waits keeps its payload.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request beat changed while stalled");

   // A response beat that is not taken holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // Nodes of one list are a subset of all allocated nodes.
   a_len_le_used: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.list_length <= rsp_data.used_nodes)
      else $error("list length exceeds nodes in use");

   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_EMPTY |-> rsp_data.list_length == 8'd0)
      else $error("empty-list status with nonzero length");

   // Allocation fails only when the whole pool is in use.
   a_nofree_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_NO_FREE |-> rsp_data.used_nodes == USED_MAX)
      else $error("no-free status while nodes remain");

endmodule

bind sorted_list_pool_with_free_list slpool_check #(.POOL_NODES(POOL_NODES)) u_slpool_check (.*);
